// ===== hdl/chacha_pkg.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 package
// Shared constants, types and the quarter-round helpers.
// ----------------------------------------------------------------------------
package chacha_pkg;

  localparam int DoubleRounds = 10;
  localparam int NumRegs      = 7;
  localparam int CfgIdxW      = 3;
  localparam int RoundCntW    = $clog2(2 * DoubleRounds + 1);

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  localparam logic [CfgIdxW-1:0] RegKey0   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey1   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey2   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKey3   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegNonce0 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegNonce1 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegStart  = 3'd6;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] state_t;

  // Entry passed from front to back: byte, position, whether a new block
  // must be computed first, and the counter for that block.
  typedef struct packed {
    logic [7:0]  data;
    logic [5:0]  pos;
    logic        need_block;
    logic [31:0] counter;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROUND,
    BK_FINAL,
    BK_EMIT
  } bk_state_t;

  function automatic word_t rotl(word_t x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [127:0] qround(word_t a, word_t b, word_t c, word_t d);
    word_t a1, b1, c1, d1;
    a1 = a + b;  d1 = rotl(d ^ a1, 16);
    c1 = c + d1; b1 = rotl(b ^ c1, 12);
    a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
    c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
    return {a1, b1, c1, d1};
  endfunction

endpackage

// ===== hdl/chacha_front.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 front end
// Accepts bytes, tracks position and block counter, queues jobs.
// ----------------------------------------------------------------------------
module chacha_front import chacha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        restart,
  input  logic [31:0] start_counter,
  output logic        job_valid,
  input  logic        job_take,
  output job_t        job
);

  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] ctr_r, ctr_nxt;
  logic        ready_r, ready_nxt;
  job_t        q_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        acc;

  assign in_full   = (cnt_r == 2'd2);
  assign acc       = in_push && !in_full;
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];

  always_comb begin
    pos_nxt   = pos_r;
    ctr_nxt   = ctr_r;
    ready_nxt = ready_r;
    if (restart) begin
      pos_nxt = '0; ctr_nxt = start_counter; ready_nxt = 1'b0;
    end else if (acc) begin
      ready_nxt = 1'b1;
      if (in_last_byte) begin
        pos_nxt = '0; ctr_nxt = start_counter; ready_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + 6'd1;
        if (pos_r == 6'd63) begin
          ready_nxt = 1'b0;
          ctr_nxt   = ctr_r + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; ctr_r <= '0; ready_r <= 1'b0;
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      pos_r <= pos_nxt; ctr_r <= ctr_nxt; ready_r <= ready_nxt;
      if (acc) wp_r <= ~wp_r;
      if (job_take) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, acc} - {1'b0, job_take};
    end
  end

  always_ff @(posedge clk) begin
    if (acc) q_r[wp_r] <= '{data: in_data_byte, pos: pos_r,
                            need_block: !ready_r, counter: ctr_r};
  end

endmodule

// ===== hdl/chacha_back.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 back end
// Iterative block function (one round per cycle) and keystream XOR.
// ----------------------------------------------------------------------------
module chacha_back import chacha_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_take,
  input  job_t          job,
  input  logic [255:0]  key,
  input  logic [95:0]   nonce,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [7:0]    out_out_byte
);

  bk_state_t            st_r, st_nxt;
  state_t               w_r, init_c, rnd_c;
  logic [511:0]         ks_r;
  logic [RoundCntW-1:0] rc_r;
  logic [7:0]           ob_r;
  logic                 ov_r;
  logic                 start_blk, emit;

  always_comb begin
    init_c[0] = Sigma0; init_c[1] = Sigma1; init_c[2] = Sigma2; init_c[3] = Sigma3;
    for (int i = 0; i < 8; i++) init_c[4 + i] = key[32*i +: 32];
    init_c[12] = job.counter;
    for (int i = 0; i < 3; i++) init_c[13 + i] = nonce[32*i +: 32];
  end

  // column round on even counts, diagonal round on odd
  always_comb begin
    if (!rc_r[0]) begin
      for (int i = 0; i < 4; i++)
        {rnd_c[i], rnd_c[4+i], rnd_c[8+i], rnd_c[12+i]} =
          qround(w_r[i], w_r[4+i], w_r[8+i], w_r[12+i]);
    end else begin
      for (int i = 0; i < 4; i++)
        {rnd_c[i], rnd_c[4+(i+1)%4], rnd_c[8+(i+2)%4], rnd_c[12+(i+3)%4]} =
          qround(w_r[i], w_r[4+(i+1)%4], w_r[8+(i+2)%4], w_r[12+(i+3)%4]);
    end
  end

  assign start_blk = (st_r == BK_IDLE) && job_valid && job.need_block;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE:  if (job_valid) st_nxt = job.need_block ? BK_ROUND : BK_EMIT;
      BK_ROUND: if (rc_r == RoundCntW'(2 * DoubleRounds - 1)) st_nxt = BK_FINAL;
      BK_FINAL: st_nxt = BK_EMIT;
      BK_EMIT:  if (!ov_r || out_pop) st_nxt = BK_IDLE;
      default:  st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    emit     = (st_r == BK_EMIT) && (!ov_r || out_pop);
    job_take = emit;
  end

  assign out_empty    = !ov_r;
  assign out_out_byte = ob_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (emit) ov_r <= 1'b1;
      else if (out_pop) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_blk) begin
      w_r <= init_c; rc_r <= '0;
    end else if (st_r == BK_ROUND) begin
      w_r <= rnd_c; rc_r <= rc_r + RoundCntW'(1);
    end
    if (st_r == BK_FINAL)
      for (int i = 0; i < 16; i++) ks_r[32*i +: 32] <= w_r[i] + init_c[i];
    if (emit) ob_r <= job.data ^ ks_r[8*job.pos +: 8];
  end

endmodule

// ===== hdl/chacha20_stream_cipher.sv =====
// A byte that opens a keystream block goes from the queue through the round
// states, final add and emit state; other bytes go through emit only. The
// back-end fetch/emit sequencer takes one byte at a time and waits while the
// output byte is unpopped; the round unit does one round per cycle.
// Reset (rst_n low, synchronous) clears config registers, queue, position.
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher top level
// Config registers, front end, job queue and round back end.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher import chacha_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [7:0]         out_out_byte,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_data
);

  logic [63:0] k0_r, k1_r, k2_r, k3_r, n0_r;
  logic [31:0] n1_r, sc_r;
  logic        wr, restart, job_valid, job_take;
  job_t        job;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;
  assign restart   = wr && (cfg_index <= RegStart);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k0_r <= '0; k1_r <= '0; k2_r <= '0; k3_r <= '0;
      n0_r <= '0; n1_r <= '0; sc_r <= '0;
    end else if (wr) begin
      unique case (cfg_index)
        RegKey0:   k0_r <= cfg_data;
        RegKey1:   k1_r <= cfg_data;
        RegKey2:   k2_r <= cfg_data;
        RegKey3:   k3_r <= cfg_data;
        RegNonce0: n0_r <= cfg_data;
        RegNonce1: n1_r <= cfg_data[31:0];
        RegStart:  sc_r <= cfg_data[31:0];
        default:   ;
      endcase
    end
  end

  // a write of the start counter itself takes effect on the same restart
  chacha_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data_byte, .in_last_byte,
    .restart,
    .start_counter((wr && (cfg_index == RegStart)) ? cfg_data[31:0] : sc_r),
    .job_valid, .job_take, .job
  );

  chacha_back u_back (
    .clk, .rst_n, .job_valid, .job_take, .job,
    .key({k3_r, k2_r, k1_r, k0_r}), .nonce({n1_r, n0_r}),
    .out_empty, .out_pop, .out_out_byte
  );

endmodule

// ===== hdl/chacha_checker.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 port checker
// Port-level properties of the cipher top level.
// ----------------------------------------------------------------------------
module chacha_checker import chacha_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_full,
  input logic out_empty,
  input logic out_pop,
  input logic [7:0] out_out_byte,
  input logic cfg_ready
);

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("output not empty after reset");
  a_not_full_after_reset: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("full after reset");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_out_byte)))
    else $error("waiting result changed");
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port stalled");

endmodule

bind chacha20_stream_cipher chacha_checker u_chk (
  .clk, .rst_n, .in_full, .out_empty, .out_pop, .out_out_byte, .cfg_ready
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher testbench
// Drives byte messages through the cipher under several key/nonce/counter
// settings and random handshake pressure; every output byte is compared
// against a behavioral keystream generator kept in the bench.
// ----------------------------------------------------------------------------
module tb_top import chacha_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [7:0]         in_data_byte = '0;
  logic               in_last_byte = 1'b0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic [7:0]         out_out_byte;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [63:0]        cfg_data = '0;

  chacha20_stream_cipher i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state
  logic [63:0] key_regs[NumRegs];
  word_t       ks_words[16];
  logic [31:0] blk_ctr;
  logic [5:0]  byte_pos;
  logic        ks_valid;

  logic [7:0]  cipher_bytes_q[$];
  int          err_cnt = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        recv_hold = 1'b0;

  typedef struct {
    logic [7:0] data;
    logic       last;
    int         known;   // -1 means no table value; else the predictor is checked against it
  } stim_row_t;

  function automatic word_t rol32(word_t x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void mix(ref word_t w[16], input int a, int b, int c, int d);
    w[a] += w[b]; w[d] = rol32(w[d] ^ w[a], 16);
    w[c] += w[d]; w[b] = rol32(w[b] ^ w[c], 12);
    w[a] += w[b]; w[d] = rol32(w[d] ^ w[a], 8);
    w[c] += w[d]; w[b] = rol32(w[b] ^ w[c], 7);
  endfunction

  function automatic void gen_keystream();
    word_t init[16];
    word_t w[16];
    init[0] = Sigma0; init[1] = Sigma1; init[2] = Sigma2; init[3] = Sigma3;
    for (int i = 0; i < 4; i++) begin
      init[4 + 2 * i] = key_regs[i][31:0];
      init[5 + 2 * i] = key_regs[i][63:32];
    end
    init[12] = blk_ctr;
    init[13] = key_regs[RegNonce0][31:0];
    init[14] = key_regs[RegNonce0][63:32];
    init[15] = key_regs[RegNonce1][31:0];
    w = init;
    for (int r = 0; r < DoubleRounds; r++) begin
      mix(w, 0, 4, 8, 12); mix(w, 1, 5, 9, 13);
      mix(w, 2, 6, 10, 14); mix(w, 3, 7, 11, 15);
      mix(w, 0, 5, 10, 15); mix(w, 1, 6, 11, 12);
      mix(w, 2, 7, 8, 13); mix(w, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) ks_words[i] = w[i] + init[i];
    ks_valid = 1'b1;
  endfunction

  function automatic void restart_msg();
    byte_pos = '0;
    ks_valid = 1'b0;
    blk_ctr  = key_regs[RegStart][31:0];
  endfunction

  function automatic logic [7:0] encrypt_byte(logic [7:0] d, logic last);
    logic [7:0] ks;
    if (!ks_valid) gen_keystream();
    ks = ks_words[byte_pos[5:2]][8 * byte_pos[1:0] +: 8];
    if (last) restart_msg();
    else begin
      byte_pos++;
      if (byte_pos == 0) begin
        ks_valid = 1'b0;
        blk_ctr++;
      end
    end
    return d ^ ks;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] exp);
    $display("mismatch %s: got %02h expected %02h at %0t", what, got, exp, $realtime);
    err_cnt++;
  endtask

  // in_push stays high across back-to-back transfers; idle cycles and
  // drain() drop it
  task automatic send_byte(logic [7:0] d, logic last, int known);
    logic [7:0] exp;
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push      <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    exp = encrypt_byte(d, last);
    if (known >= 0 && exp != known[7:0]) report_mismatch("table", exp, known[7:0]);
    cipher_bytes_q.push_back(exp);
  endtask

  // Long receiver hold-off
  initial begin
    wait (hold_go);
    @(posedge clk);
    recv_hold <= 1'b1;
    repeat (400) @(posedge clk);
    recv_hold <= 1'b0;
  end

  // Receiver
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (cipher_bytes_q.size() == 0) report_mismatch("unexpected", out_out_byte, 8'h00);
      else begin
        logic [7:0] exp;
        exp = cipher_bytes_q.pop_front();
        if (out_out_byte !== exp) report_mismatch("out_byte", out_out_byte, exp);
      end
    end
    if (recv_hold) out_pop <= 1'b0;
    else out_pop <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
  end

  task automatic drain();
    in_push <= 1'b0;
    while (cipher_bytes_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx < NumRegs) begin
      key_regs[idx] = (idx >= RegNonce1) ? {32'h0, val[31:0]} : val;
      restart_msg();
    end
  endtask

  task automatic load_all(logic [63:0] k0, k1, k2, k3, n0, logic [31:0] n1, ctr);
    write_reg(RegKey0, k0);
    write_reg(RegKey1, k1);
    write_reg(RegKey2, k2);
    write_reg(RegKey3, k3);
    write_reg(RegNonce0, n0);
    write_reg(RegNonce1, {32'h0, n1});
    write_reg(RegStart, {32'h0, ctr});
  endtask

  task automatic random_msgs(int n_bytes);
    int len;
    while (n_bytes > 0) begin
      len = ($urandom_range(9, 0) == 0) ? $urandom_range(200, 60) : $urandom_range(20, 1);
      for (int i = 0; i < len && n_bytes > 0; i++, n_bytes--)
        send_byte(8'($urandom_range(255, 0)), i == len - 1, -1);
    end
  endtask

  stim_row_t dir_rows[$];

  initial begin
    for (int i = 0; i < NumRegs; i++) key_regs[i] = '0;
    restart_msg();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // All-zero key/nonce/counter: first keystream bytes are 76 b8 e0 ad
    dir_rows = '{'{8'h00, 1'b0, 8'h76}, '{8'hff, 1'b0, 8'h47}, '{8'h00, 1'b0, 8'he0},
                 '{8'h00, 1'b1, 8'had}, '{8'h00, 1'b1, 8'h76}, '{8'hff, 1'b0, 8'h89},
                 '{8'h55, 1'b0, -1}, '{8'haa, 1'b1, -1}};
    foreach (dir_rows[i]) send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].known);
    // Crossing a block boundary, then wrap of the counter at all-ones
    for (int i = 0; i < 66; i++) send_byte(i[7:0], i == 65, -1);
    drain();
    load_all('1, '1, '1, '1, '1, 32'hffff_ffff, 32'hffff_ffff);
    for (int i = 0; i < 70; i++) send_byte(8'hff - i[7:0], 1'b0, -1);
    drain();
    // Out-of-range index is ignored and keeps the message going
    write_reg(NumRegs, 64'h1234);
    for (int i = 0; i < 8; i++) send_byte(8'($urandom_range(255, 0)), i == 7, -1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      if (ph == 0) load_all('0, '0, '0, '0, '0, 32'h0, 32'h0);
      else load_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                    (ph == 3) ? 32'hffff_fffe : $urandom);
      if (ph == 2) hold_go = 1'b1;
      random_msgs(370);
      drain();
    end

    if (err_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
